// ===== design/rhc_pkg.sv =====
package rhc_pkg;

	// Width of one hue sector in whole degrees, and sectors per turn
	localparam int DEG_PER_SECTOR = 60;
	localparam int SECTORS_PER_TURN = 6;

	// Which channel holds the maximum (red wins ties over green, green over blue)
	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// Per-beat control that travels down the divider pipeline
	typedef struct packed {
		logic    valid;
		sector_t sector;
		logic    neg;
		logic    grey;
	} ctl_t;

endpackage

// ===== design/rhc_div_step.sv =====
// One registered restoring-division step for both the hue and the saturation
// quotient, plus the control and lightness that ride along with the beat.
module rhc_div_step import rhc_pkg::*; #(
	parameter int CB = 8,
	parameter int NSTEP = 13,
	parameter int LW = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ce,
	input  ctl_t             ctl_in,
	input  logic [LW-1:0]    sum_in,
	input  logic [CB-1:0]    hdiv_in,
	input  logic [CB-1:0]    hrem_in,
	input  logic [NSTEP-1:0] hsr_in,
	input  logic [CB-1:0]    sdiv_in,
	input  logic [CB-1:0]    srem_in,
	input  logic [NSTEP-1:0] ssr_in,
	output ctl_t             ctl_q,
	output logic [LW-1:0]    sum_q,
	output logic [CB-1:0]    hdiv_q,
	output logic [CB-1:0]    hrem_q,
	output logic [NSTEP-1:0] hsr_q,
	output logic [CB-1:0]    sdiv_q,
	output logic [CB-1:0]    srem_q,
	output logic [NSTEP-1:0] ssr_q
);

	logic [CB:0]   htrial, strial;
	logic [CB:0]   hdiff, sdiff;
	logic          hge, sge;
	logic [CB-1:0] hrem_n, srem_n;

	// shift in the next numerator bit, subtract when it fits
	always_comb begin
		htrial = {hrem_in, hsr_in[NSTEP-1]};
		strial = {srem_in, ssr_in[NSTEP-1]};
		hdiff  = htrial - {1'b0, hdiv_in};
		sdiff  = strial - {1'b0, sdiv_in};
		hge    = htrial >= {1'b0, hdiv_in};
		sge    = strial >= {1'b0, sdiv_in};
		hrem_n = hge ? hdiff[CB-1:0] : htrial[CB-1:0];
		srem_n = sge ? sdiff[CB-1:0] : strial[CB-1:0];
	end

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (ce) begin
			ctl_q <= ctl_in;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ce) begin
			sum_q  <= sum_in;
			hdiv_q <= hdiv_in;
			sdiv_q <= sdiv_in;
			hrem_q <= hrem_n;
			srem_q <= srem_n;
			hsr_q  <= {hsr_in[NSTEP-2:0], hge};
			ssr_q  <= {ssr_in[NSTEP-2:0], sge};
		end
	end

endmodule

// ===== design/rgb_to_hsl_converter_top.sv =====
// RGB to HSL pixel converter.
// Input stream (s_*): one pixel per beat, tdata = {blue, green, red} with red
// in the lowest bits. Output stream (m_*): one result per pixel, in order,
// tdata = {lightness_sum, saturation, hue} with hue in the lowest bits.
// Hue is in 1/2^HUE_FRAC_BITS degree, saturation in Q1.SAT_FRAC_BITS,
// lightness_sum is max + min channel.
// Throughput: one pixel per clock while the receiver does not stall. The pipeline
// is two front stages, then NSTEP restoring-divider stages with one quotient bit
// per stage, where NSTEP is the larger of the hue and saturation quotient widths
// (13 at the default parameters), then an output register.
// Reset empties the pipeline: m_tvalid drops and s_tready goes high.
// When the receiver stalls, the whole pipeline holds and s_tready drops in
// the same cycle; no beat is dropped or repeated. Bubbles on the input pass
// through as empty stages.
module rgb_to_hsl_converter_top import rhc_pkg::*; #(
	parameter int CHANNEL_BITS = 8,
	parameter int HUE_FRAC_BITS = 6,
	parameter int SAT_FRAC_BITS = 12,
	localparam int SECTOR = DEG_PER_SECTOR * (2 ** HUE_FRAC_BITS),
	localparam int HUE_W = $clog2(SECTORS_PER_TURN * SECTOR),
	localparam int SAT_W = SAT_FRAC_BITS + 1,
	localparam int LIGHT_W = CHANNEL_BITS + 1,
	localparam int IN_TW = ((3 * CHANNEL_BITS + 7) / 8) * 8,
	localparam int OUT_TW = ((HUE_W + SAT_W + LIGHT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,  // red, green, blue
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata   // hue, saturation, lightness_sum
);

	localparam int CB = CHANNEL_BITS;
	localparam int QW = $clog2(SECTOR + 1);
	localparam int NSTEP = (QW > SAT_W) ? QW : SAT_W;
	localparam int NW = CB + NSTEP;
	localparam int OUT_W = HUE_W + SAT_W + LIGHT_W;
	localparam logic [QW-1:0] SECTOR_C = QW'(SECTOR);
	localparam logic [HUE_W-1:0] BASE_GREEN = HUE_W'(2 * SECTOR);
	localparam logic [HUE_W-1:0] BASE_BLUE = HUE_W'(4 * SECTOR);
	localparam logic [HUE_W-1:0] BASE_WRAP = HUE_W'(SECTORS_PER_TURN * SECTOR);
	localparam logic [LIGHT_W-1:0] FULL = {1'b0, {CB{1'b1}}};
	localparam logic [LIGHT_W-1:0] TWO_FULL = {{CB{1'b1}}, 1'b0};

	logic ce;

	logic [CB-1:0] red, green, blue;
	logic [CB-1:0] mx, mn, minu, subt;
	logic [LIGHT_W-1:0] sum, den_hi;
	sector_t sector;

	ctl_t ctl_s1;
	logic [CB-1:0] mag_s1, d_s1, den_s1;
	logic [LIGHT_W-1:0] sum_s1;

	logic [NW-1:0] hnum, snum;
	ctl_t ctl_s2;
	logic [LIGHT_W-1:0] sum_s2;
	logic [CB-1:0] hdiv_s2, sdiv_s2, hrem_s2, srem_s2;
	logic [NSTEP-1:0] hsr_s2, ssr_s2;

	ctl_t ctl_w [0:NSTEP];
	logic [LIGHT_W-1:0] sum_w [0:NSTEP];
	logic [CB-1:0] hdiv_w [0:NSTEP];
	logic [CB-1:0] hrem_w [0:NSTEP];
	logic [NSTEP-1:0] hsr_w [0:NSTEP];
	logic [CB-1:0] sdiv_w [0:NSTEP];
	logic [CB-1:0] srem_w [0:NSTEP];
	logic [NSTEP-1:0] ssr_w [0:NSTEP];

	ctl_t ctl_l;
	logic [HUE_W-1:0] qh, base, hue_n;
	logic carry;

	logic valid_q;
	logic [HUE_W-1:0] hue_q;
	logic [SAT_W-1:0] sat_q;
	logic [LIGHT_W-1:0] light_q;

	// the whole pipeline advances unless the output beat is held
	assign ce = !valid_q || m_tready;
	assign s_tready = ce;

	// stage 1: max, min, sector, signed difference and divisors
	always_comb begin
		red   = s_tdata[CB-1:0];
		green = s_tdata[2*CB-1:CB];
		blue  = s_tdata[3*CB-1:2*CB];
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (red >= green && red >= blue) begin
			sector = SEC_RED;
			minu = green;
			subt = blue;
		end else if (green >= blue) begin
			sector = SEC_GREEN;
			minu = blue;
			subt = red;
		end else begin
			sector = SEC_BLUE;
			minu = red;
			subt = green;
		end
		sum    = {1'b0, mx} + {1'b0, mn};
		den_hi = TWO_FULL - sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (ce) begin
			ctl_s1.valid  <= s_tvalid;
			ctl_s1.sector <= sector;
			ctl_s1.neg    <= minu < subt;
			ctl_s1.grey   <= mx == mn;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			mag_s1 <= (minu < subt) ? (subt - minu) : (minu - subt);
			d_s1   <= mx - mn;
			sum_s1 <= sum;
			den_s1 <= (sum <= FULL) ? sum[CB-1:0] : den_hi[CB-1:0];
		end
	end

	// stage 2: hue numerator product, saturation numerator, divider seed
	always_comb begin
		hnum = NW'(mag_s1) * NW'(SECTOR_C);
		snum = NW'(d_s1) << SAT_FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (ce) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sum_s2  <= sum_s1;
			hdiv_s2 <= d_s1;
			sdiv_s2 <= den_s1;
			hrem_s2 <= hnum[NW-1:NSTEP];
			hsr_s2  <= hnum[NSTEP-1:0];
			srem_s2 <= snum[NW-1:NSTEP];
			ssr_s2  <= snum[NSTEP-1:0];
		end
	end

	assign ctl_w[0]  = ctl_s2;
	assign sum_w[0]  = sum_s2;
	assign hdiv_w[0] = hdiv_s2;
	assign hrem_w[0] = hrem_s2;
	assign hsr_w[0]  = hsr_s2;
	assign sdiv_w[0] = sdiv_s2;
	assign srem_w[0] = srem_s2;
	assign ssr_w[0]  = ssr_s2;

	// divider stages, one quotient bit each
	for (genvar k = 0; k < NSTEP; k++) begin : g_div
		rhc_div_step #(
			.CB(CB),
			.NSTEP(NSTEP),
			.LW(LIGHT_W)
		) u_step (
			.clk(clk),
			.arst_n(arst_n),
			.ce(ce),
			.ctl_in(ctl_w[k]),
			.sum_in(sum_w[k]),
			.hdiv_in(hdiv_w[k]),
			.hrem_in(hrem_w[k]),
			.hsr_in(hsr_w[k]),
			.sdiv_in(sdiv_w[k]),
			.srem_in(srem_w[k]),
			.ssr_in(ssr_w[k]),
			.ctl_q(ctl_w[k+1]),
			.sum_q(sum_w[k+1]),
			.hdiv_q(hdiv_w[k+1]),
			.hrem_q(hrem_w[k+1]),
			.hsr_q(hsr_w[k+1]),
			.sdiv_q(sdiv_w[k+1]),
			.srem_q(srem_w[k+1]),
			.ssr_q(ssr_w[k+1])
		);
	end

	// final stage: sector base, floor for negative offsets, wrap, zero hue for grey
	always_comb begin
		ctl_l = ctl_w[NSTEP];
		qh    = HUE_W'(hsr_w[NSTEP][QW-1:0]);
		carry = |hrem_w[NSTEP];
		case (ctl_l.sector)
			SEC_RED:   base = ctl_l.neg ? BASE_WRAP : '0;
			SEC_GREEN: base = BASE_GREEN;
			SEC_BLUE:  base = BASE_BLUE;
			default:   base = '0;
		endcase
		if (ctl_l.grey) begin
			hue_n = '0;
		end else if (ctl_l.neg) begin
			hue_n = base - qh - HUE_W'(carry);
		end else begin
			hue_n = base + qh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ce) begin
			valid_q <= ctl_l.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			hue_q   <= hue_n;
			sat_q   <= ctl_l.grey ? '0 : ssr_w[NSTEP][SAT_W-1:0];
			light_q <= sum_w[NSTEP];
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OUT_TW - OUT_W){1'b0}}, light_q, sat_q, hue_q};

endmodule

// ===== design/rhc_checker.sv =====
// Port-level checks for the RGB to HSL converter.
module rhc_checker import rhc_pkg::*; #(
	parameter int CHANNEL_BITS = 8,
	parameter int HUE_FRAC_BITS = 6,
	parameter int SAT_FRAC_BITS = 12,
	localparam int SECTOR = DEG_PER_SECTOR * (2 ** HUE_FRAC_BITS),
	localparam int HUE_W = $clog2(SECTORS_PER_TURN * SECTOR),
	localparam int SAT_W = SAT_FRAC_BITS + 1,
	localparam int LIGHT_W = CHANNEL_BITS + 1,
	localparam int IN_TW = ((3 * CHANNEL_BITS + 7) / 8) * 8,
	localparam int OUT_TW = ((HUE_W + SAT_W + LIGHT_W + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [IN_TW-1:0]  s_tdata,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_TW-1:0] m_tdata
);

	localparam logic [HUE_W-1:0] HUE_LIMIT = HUE_W'(SECTORS_PER_TURN * SECTOR);
	localparam logic [SAT_W-1:0] SAT_ONE = SAT_W'(2 ** SAT_FRAC_BITS);
	localparam logic [LIGHT_W-1:0] LIGHT_MAX = {{CHANNEL_BITS{1'b1}}, 1'b0};

	logic [HUE_W-1:0] hue;
	logic [SAT_W-1:0] sat;
	logic [LIGHT_W-1:0] light;

	assign hue   = m_tdata[HUE_W-1:0];
	assign sat   = m_tdata[HUE_W+SAT_W-1:HUE_W];
	assign light = m_tdata[HUE_W+SAT_W+LIGHT_W-1:HUE_W+SAT_W];

	// a held result beat stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat withdrawn while stalled");

	// a held result beat keeps its data
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// input is taken exactly when the output slot frees up
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// result fields stay in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hue < HUE_LIMIT) && (sat <= SAT_ONE) && (light <= LIGHT_MAX))
		else $error("result field out of range");

	// an accepted pixel beat carries known channel data
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !$isunknown(s_tdata[3*CHANNEL_BITS-1:0]))
		else $error("pixel beat accepted with unknown data");

endmodule

bind rgb_to_hsl_converter_top rhc_checker #(
	.CHANNEL_BITS(CHANNEL_BITS),
	.HUE_FRAC_BITS(HUE_FRAC_BITS),
	.SAT_FRAC_BITS(SAT_FRAC_BITS)
) u_rhc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata(s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
	import rhc_pkg::*;

	localparam int HUE_SECTOR = DEG_PER_SECTOR * 64;
	localparam int CH_FULL = 255;

	typedef struct packed {
		logic [14:0] hue;
		logic [12:0] sat;
		logic [8:0]  light;
	} hsl_t;

	// Holds the expected HSL values of accepted pixels, in order
	class hsl_scoreboard;
		hsl_t expected_q[$];
		int mismatches = 0;

		// Exact fixed-point RGB to HSL conversion
		function hsl_t convert_pixel(int r, int g, int b);
			int mx, mn, sum, d, den, num, q, base, hue, sat;
			hsl_t res;
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			sum = mx + mn;
			d = mx - mn;
			hue = 0;
			sat = 0;
			if (d != 0) begin
				den = (sum <= CH_FULL) ? sum : (2 * CH_FULL - sum);
				sat = (d << 12) / den;
				// red wins ties over green, green over blue
				if (r == mx) begin
					base = 0;
					num = HUE_SECTOR * (g - b);
				end else if (g == mx) begin
					base = 2 * HUE_SECTOR;
					num = HUE_SECTOR * (b - r);
				end else begin
					base = 4 * HUE_SECTOR;
					num = HUE_SECTOR * (r - g);
				end
				// floor toward minus infinity
				q = num / d;
				if (num < 0 && (num % d) != 0)
					q = q - 1;
				hue = base + q;
				if (hue < 0)
					hue = hue + SECTORS_PER_TURN * HUE_SECTOR;
			end
			res.hue = hue[14:0];
			res.sat = sat[12:0];
			res.light = sum[8:0];
			return res;
		endfunction

		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			expected_q.push_back(convert_pixel(int'(r), int'(g), int'(b)));
		endfunction

		function void check_result(hsl_t got);
			hsl_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: hue %0d sat %0d light %0d",
						$time, got.hue, got.sat, got.light);
				return;
			end
			want = expected_q.pop_front();
			if (got.hue !== want.hue || got.sat !== want.sat || got.light !== want.light) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: hue %0d/%0d sat %0d/%0d light %0d/%0d (exp/got)",
						$time, want.hue, got.hue, want.sat, got.sat, want.light, got.light);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // red, green, blue
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;       // hue, saturation, lightness_sum

	int sender_idle_pct = 27;
	int receiver_idle_pct = 53;
	bit hold_request = 1'b0;
	int stall_left = 0;

	hsl_scoreboard sb = new;

	rgb_to_hsl_converter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: random backpressure, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// Output monitor: one beat per edge where valid and ready were both high
	always @(posedge clk) begin
		hsl_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.hue = m_tdata[14:0];
			got.sat = m_tdata[27:15];
			got.light = m_tdata[36:28];
			sb.check_result(got);
		end
	end

	// Offer one pixel, idling at random first; returns once the beat is taken
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, g, r};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_pixel(r, g, b);
	endtask

	// Random pixel biased toward grey, near-grey, ties, extremes and the lightness midpoint
	task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
			output logic [7:0] b);
		int kind, hi, lo, pick, c0, c1, c2;
		kind = $urandom_range(9);
		c0 = $urandom_range(255);
		c1 = $urandom_range(255);
		c2 = $urandom_range(255);
		case (kind)
			5: begin
				c1 = c0;
				c2 = c0;
			end
			6: begin
				hi = $urandom_range(255, 1);
				lo = $urandom_range(hi - 1, 0);
				c0 = hi;
				c1 = hi;
				c2 = lo;
			end
			7: begin
				pick = $urandom_range(7);
				if (pick[0]) c0 = $urandom_range(1) * 255;
				if (pick[1]) c1 = $urandom_range(1) * 255;
				if (pick[2]) c2 = $urandom_range(1) * 255;
			end
			8: begin
				lo = $urandom_range(250);
				c0 = lo + $urandom_range(3);
				c1 = lo + $urandom_range(3);
				c2 = lo + $urandom_range(3);
			end
			9: begin
				hi = $urandom_range(255, 128);
				c0 = hi;
				c1 = 255 - hi + $urandom_range(2);
				if (c1 > hi) c1 = hi;
			end
			default: ;
		endcase
		// rotate so every channel takes every role
		case ($urandom_range(2))
			0: begin r = 8'(c0); g = 8'(c1); b = 8'(c2); end
			1: begin r = 8'(c2); g = 8'(c0); b = 8'(c1); end
			default: begin r = 8'(c1); g = 8'(c2); b = 8'(c0); end
		endcase
	endtask

	task automatic random_run(input int count);
		logic [7:0] r, g, b;
		repeat (count) begin
			random_pixel(r, g, b);
			send_pixel(r, g, b);
		end
	endtask

	// Main sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: greys, primaries, ties, negative hue, lightness midpoint
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd200, 8'd200, 8'd100);
		send_pixel(8'd100, 8'd200, 8'd200);
		send_pixel(8'd255, 8'd0, 8'd10);
		send_pixel(8'd255, 8'd200, 8'd100);
		send_pixel(8'd200, 8'd55, 8'd0);
		send_pixel(8'd200, 8'd56, 8'd0);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd1, 8'd1);
		send_pixel(8'd128, 8'd64, 8'd200);
		send_pixel(8'd10, 8'd20, 8'd30);
		send_pixel(8'd170, 8'd85, 8'd170);

		random_run(370);

		sender_idle_pct = 53;
		receiver_idle_pct = 27;
		random_run(370);

		// no idling; a long receiver hold-off fills the pipeline
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		hold_request = 1'b1;
		random_run(370);
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
